// File: rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared widths, codes and rule constants for the life grid step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Size registers and cell coordinates
  localparam int CFG_W    = 7;
  localparam int CELL_R_W = 6;
  localparam int CELL_C_W = 6;
  localparam int CNT_W    = CFG_W + 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // Item function codes
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Neighbor count and B3/S23 rule
  localparam int NB_W = 4;
  localparam logic [NB_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NB_W-1:0] STAY_COUNT  = 4'd2;

endpackage

// File: rtl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Toroidal B3/S23 cell grid held one row per memory word, with cell write,
// cell read and whole-grid generation step items.
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  --------  -----------------------------------------  ---------
//  input     in_valid/in_ready, func, cell_row,         into block
//            cell_col, cell_value
//  output    out_valid/out_ready, cell_alive            out of block
//  config    psel, penable, pwrite, paddr, pwdata,      APB slave
//            prdata, pready (rows at 0x0, cols at 0x4)
//
//  A cell write or read is accepted together with the row read of the grid
//  memory (the write port then stores the modified row).
//  In a step the sweep reads one row per cycle through the single read port,
//  then rows outside the height in use are zeroed one per cycle through the
//  write port.
//  After reset a clearing pass zeroes all MAX_ROWS rows, one per cycle; no
//  item is accepted during it, register writes are taken.
//  A read item whose result finds the output register still full waits there
//  until out_ready frees it; writes and steps go on regardless.
//
module life_grid_generation_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lgs_pkg::FUNC_W-1:0]      func,
  input  logic [lgs_pkg::CELL_R_W-1:0]    cell_row,
  input  logic [lgs_pkg::CELL_C_W-1:0]    cell_col,
  input  logic                            cell_value,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            cell_alive,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lgs_pkg::APB_AW-1:0]      paddr,
  input  logic [lgs_pkg::APB_DW-1:0]      pwdata,
  output logic [lgs_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int CFG_MAX = (1 << lgs_pkg::CFG_W) - 1;
  localparam logic [lgs_pkg::CFG_W-1:0] ROW_CAP =
    lgs_pkg::CFG_W'((MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS);
  localparam logic [lgs_pkg::CFG_W-1:0] COL_CAP =
    lgs_pkg::CFG_W'((MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CELL  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  // Grid memory: one word per row
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];

  logic [1:0]                   state;
  logic [lgs_pkg::CFG_W-1:0]    grid_rows, grid_cols;
  logic [lgs_pkg::CFG_W-1:0]    rows_used, cols_used;
  logic [lgs_pkg::CNT_W-1:0]    rows_plus1;

  // held item
  logic [lgs_pkg::FUNC_W-1:0]   op_func;
  logic [lgs_pkg::CELL_R_W-1:0] op_row;
  logic [lgs_pkg::CELL_C_W-1:0] op_col;
  logic                         op_value;
  logic                         op_inside;

  // memory ports
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [MAX_COLS-1:0] rd_data, wr_data, row_mod;

  // clearing pass
  logic [AW-1:0]       clr_addr;

  // sweep pipeline: issue -> arrival -> window write
  logic                         iss_on;
  logic [lgs_pkg::CNT_W-1:0]    iss;
  logic                         arr_v;
  logic [lgs_pkg::CNT_W-1:0]    arr_idx;
  logic                         win_v;
  logic [AW-1:0]                win_row;
  logic [MAX_COLS-1:0]          win_top, win_mid, win_bot, row0_old, arr_data;
  logic [MAX_COLS-1:0]          row_next;
  logic                         sweep_done;

  logic in_acc, cfg_wr, out_free;

  // Saturate size registers: zero acts as one, above the maximum acts as it
  always_comb begin
    if (grid_rows == '0) begin
      rows_used = lgs_pkg::CFG_W'(1);
    end else if (grid_rows > ROW_CAP) begin
      rows_used = ROW_CAP;
    end else begin
      rows_used = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_used = lgs_pkg::CFG_W'(1);
    end else if (grid_cols > COL_CAP) begin
      cols_used = COL_CAP;
    end else begin
      cols_used = grid_cols;
    end
  end

  assign rows_plus1 = lgs_pkg::CNT_W'(rows_used) + lgs_pkg::CNT_W'(1);

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == lgs_pkg::REG_COLS) ? lgs_pkg::APB_DW'(grid_cols)
                                                 : lgs_pkg::APB_DW'(grid_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= lgs_pkg::SIZE_RESET;
      grid_cols <= lgs_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lgs_pkg::REG_COLS) begin
        grid_cols <= pwdata[lgs_pkg::CFG_W-1:0];
      end else begin
        grid_rows <= pwdata[lgs_pkg::CFG_W-1:0];
      end
    end
  end

  // Handshakes
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign op_inside = (lgs_pkg::CFG_W'(op_row) < rows_used) &&
                     (lgs_pkg::CFG_W'(op_col) < cols_used);

  // Cell write: patch one bit of the fetched row
  always_comb begin
    row_mod = rd_data;
    if (op_inside) begin
      row_mod[CW'(op_col)] = op_value;
    end
  end

  // Sweep arrival: the last window row is old row 0, kept aside before its
  // in-place overwrite
  assign arr_data   = (arr_idx == rows_plus1) ? row0_old : rd_data;
  assign sweep_done = win_v && (win_row == AW'(rows_used - lgs_pkg::CFG_W'(1)));

  lgs_row_rule #(
    .NCOLS(MAX_COLS)
  ) u_rule (
    .row_above (win_top),
    .row_here  (win_mid),
    .row_below (win_bot),
    .cols_used (cols_used),
    .row_next  (row_next)
  );

  // Memory port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_IDLE: begin
        rd_en   = in_valid && ((func == lgs_pkg::FUNC_WRITE) ||
                               (func == lgs_pkg::FUNC_READ));
        rd_addr = AW'(cell_row);
      end
      ST_CELL: begin
        wr_en   = (op_func == lgs_pkg::FUNC_WRITE) && op_inside;
        wr_addr = AW'(op_row);
        wr_data = row_mod;
      end
      ST_SWEEP: begin
        // read order: last row, then rows 0 .. last
        rd_en   = iss_on && (iss != rows_plus1);
        rd_addr = (iss == '0) ? AW'(rows_used - lgs_pkg::CFG_W'(1))
                              : AW'(iss - lgs_pkg::CNT_W'(1));
        wr_en   = win_v;
        wr_addr = win_row;
        wr_data = row_next;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= grid_mem[rd_addr];
    end
  end

  // Hold the item under work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_func  <= func;
      op_row   <= cell_row;
      op_col   <= cell_col;
      op_value <= cell_value;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      iss_on   <= 1'b0;
      iss      <= '0;
      arr_v    <= 1'b0;
      win_v    <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(MAX_ROWS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if ((func == lgs_pkg::FUNC_WRITE) || (func == lgs_pkg::FUNC_READ)) begin
              state <= ST_CELL;
            end else if (func == lgs_pkg::FUNC_STEP) begin
              state  <= ST_SWEEP;
              iss_on <= 1'b1;
              iss    <= '0;
            end
          end
        end
        ST_CELL: begin
          // a read waits here while the output register is still full
          if ((op_func != lgs_pkg::FUNC_READ) || out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          // issue stage
          if (iss_on) begin
            iss <= iss + lgs_pkg::CNT_W'(1);
            if (iss == rows_plus1) begin
              iss_on <= 1'b0;
            end
          end
          arr_v   <= iss_on;
          arr_idx <= iss;
          // arrival stage: shift the three-row window
          win_v <= arr_v && (arr_idx >= lgs_pkg::CNT_W'(2));
          if (arr_v) begin
            win_top <= win_mid;
            win_mid <= win_bot;
            win_bot <= arr_data;
            win_row <= AW'(arr_idx - lgs_pkg::CNT_W'(2));
            if (arr_idx == lgs_pkg::CNT_W'(1)) begin
              row0_old <= rd_data;
            end
          end
          // write stage ends the sweep; zero rows past the height in use
          if (sweep_done) begin
            if (int'(rows_used) < MAX_ROWS) begin
              state    <= ST_CLEAR;
              clr_addr <= AW'(rows_used);
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_CELL) && (op_func == lgs_pkg::FUNC_READ) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CELL) && (op_func == lgs_pkg::FUNC_READ) && out_free) begin
      cell_alive <= op_inside && rd_data[CW'(op_col)];
    end
  end

`ifndef ASSERT_OFF
  // A sweep never reads the row it is writing back
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("grid row read and written in the same cycle");

  // Sweep write-back stays inside the height in use
  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SWEEP) && wr_en) |-> (int'(wr_addr) < int'(rows_used)))
    else $error("sweep wrote a row outside the grid in use");

  // A new result only follows a read item
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (($past(state) == ST_CELL) &&
                          ($past(op_func) == lgs_pkg::FUNC_READ)))
    else $error("result raised without a read item");
`endif

endmodule

// File: rtl/lgs_row_rule.sv
// ----------------------------------------------------------------------------
// lgs_row_rule
// Next generation of one grid row from a three-row window, wrapping columns.
// ----------------------------------------------------------------------------
module lgs_row_rule #(
  parameter int NCOLS = 64
) (
  input  logic [NCOLS-1:0]             row_above,
  input  logic [NCOLS-1:0]             row_here,
  input  logic [NCOLS-1:0]             row_below,
  input  logic [lgs_pkg::CFG_W-1:0]    cols_used,
  output logic [NCOLS-1:0]             row_next
);

  int cols_i;
  logic [NCOLS-1:0] above_l, above_r, here_l, here_r, below_l, below_r;

  // v[c] is the wrapped left neighbor of column c
  function automatic logic [NCOLS-1:0] from_left(logic [NCOLS-1:0] r, int last);
    logic [NCOLS-1:0] v;
    v = '0;
    v[0] = r[last];
    for (int c = 1; c < NCOLS; c++) begin
      v[c] = r[c-1];
    end
    return v;
  endfunction

  // v[c] is the wrapped right neighbor of column c
  function automatic logic [NCOLS-1:0] from_right(logic [NCOLS-1:0] r, int last);
    logic [NCOLS-1:0] v;
    v = '0;
    for (int c = 0; c < NCOLS; c++) begin
      if (c == last) begin
        v[c] = r[0];
      end else if (c < NCOLS - 1) begin
        v[c] = r[c+1];
      end else begin
        v[c] = 1'b0;
      end
    end
    return v;
  endfunction

  assign cols_i = int'(cols_used);

  always_comb begin
    above_l = from_left(row_above, cols_i - 1);
    above_r = from_right(row_above, cols_i - 1);
    here_l  = from_left(row_here, cols_i - 1);
    here_r  = from_right(row_here, cols_i - 1);
    below_l = from_left(row_below, cols_i - 1);
    below_r = from_right(row_below, cols_i - 1);
  end

  for (genvar c = 0; c < NCOLS; c++) begin : g_col
    logic [lgs_pkg::NB_W-1:0] nb;
    assign nb = lgs_pkg::NB_W'(above_l[c]) + lgs_pkg::NB_W'(row_above[c])
              + lgs_pkg::NB_W'(above_r[c]) + lgs_pkg::NB_W'(here_l[c])
              + lgs_pkg::NB_W'(here_r[c])  + lgs_pkg::NB_W'(below_l[c])
              + lgs_pkg::NB_W'(row_below[c]) + lgs_pkg::NB_W'(below_r[c]);
    // columns past the width in use die
    assign row_next[c] = (c < cols_i) &&
                         ((nb == lgs_pkg::BIRTH_COUNT) ||
                          (row_here[c] && (nb == lgs_pkg::STAY_COUNT)));
  end

endmodule
